/* hw/rtl/ttiu_pkg.sv */
// Shared types and constants for the tag table block.
package ttiu_pkg;

    localparam int KEY_W     = 16;
    localparam int SLOT_W    = 6;
    localparam int ADDR_W    = 8;
    localparam int COUNT_W   = 7;
    localparam int ENTRY_W   = KEY_W + 2;

    localparam logic ACTION_LOOKUP = 1'b0;
    localparam logic ACTION_STORE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [1:0] RECORD_BASE = 2'b10;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] entry_count;
        logic [ADDR_W-1:0]  record_address;
        logic               entry_stolen;
        logic               entry_enabled;
        logic [SLOT_W-1:0]  slot;
        logic               found;
    } result_t;

endpackage

/* hw/rtl/tag_table_insert_update_lookup.sv */
// Top level of the tag table: sequencer, entry memory and output register.
//
// Input channel s_axis carries one request item: s_axis_tuser selects lookup
// or store, s_axis_tdata holds the tag id and its flags. Output channel
// m_axis returns exactly one result item per request: found, slot, flags,
// record address and entry count in m_axis_tdata, the full status in
// m_axis_tuser.
// A request scans the valid entries in slot order, one per cycle through a
// single key comparator and the memory read port. A miss scans all valid
// entries before its result goes to m_axis; a hit at slot h ends the scan
// early. The next request is taken in the cycle after a result is handed off.
// s_axis_tready is high only while the sequencer is idle.
// A finished result sits in the output register; the next request is taken
// while it waits. When the receiver stalls, the sequencer holds its result
// and the table write until the output register is free.
// Reset clears the entry count, so the table starts empty; no clearing pass
// is needed and the block is ready as soon as reset is released.
module tag_table_insert_update_lookup #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // tag_id[15:0], tag_enabled[16], tag_stolen[17], zero
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // found, slot, entry_enabled, entry_stolen,
                                        // record_address, entry_count
    output logic        m_axis_tuser    // status
);
    import ttiu_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg, out_res_next;

    ttiu_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_key     (s_axis_tdata[15:0]),
        .in_enabled (s_axis_tdata[16]),
        .in_stolen  (s_axis_tdata[17]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    ttiu_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.entry_count, out_res_reg.record_address,
                            out_res_reg.entry_stolen, out_res_reg.entry_enabled,
                            out_res_reg.slot, out_res_reg.found};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

/* hw/rtl/ttiu_table.sv */
// Tag entry memory: one write port, one read port with registered data.
module ttiu_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [ttiu_pkg::ENTRY_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [ttiu_pkg::ENTRY_W-1:0] rd_data
);
    import ttiu_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/ttiu_seq.sv */
// Search sequencer: scans the table one entry a cycle by a shared compare; stores may write back.
module ttiu_seq #(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_action,
    input  logic [ttiu_pkg::KEY_W-1:0]   in_key,
    input  logic                         in_enabled,
    input  logic                         in_stolen,
    output logic                         res_valid,
    input  logic                         res_ready,
    output ttiu_pkg::result_t            res,
    output logic                         wr_en,
    output logic [IDX_W-1:0]             wr_addr,
    output logic [ttiu_pkg::ENTRY_W-1:0] wr_data,
    output logic                         rd_en,
    output logic [IDX_W-1:0]             rd_addr,
    input  logic [ttiu_pkg::ENTRY_W-1:0] rd_data
);
    import ttiu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               act_reg, act_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               en_reg, en_next;
    logic               st_reg, st_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               hit_en_reg, hit_en_next;
    logic               hit_st_reg, hit_st_next;

    logic               issue;
    logic               match;
    logic               full;
    logic [CNT_W-1:0]   sel_slot;
    logic               written;

    assign issue = idx_reg < count_reg;
    assign match = cmp_valid_reg && (rd_data[ENTRY_W-1 -: KEY_W] == key_reg);
    assign full  = count_reg == CNT_W'(TABLE_DEPTH);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        en_next        = en_reg;
        st_next        = st_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_en_next    = hit_en_reg;
        hit_st_next    = hit_st_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;
        wr_data        = {key_reg, en_reg, st_reg};
        sel_slot       = '0;
        written        = 1'b0;
        res            = '0;
        res.status     = STATUS_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act_next       = in_action;
                    key_next       = in_key;
                    en_next        = in_enabled;
                    st_next        = in_stolen;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_en_next    = rd_data[1];
                    hit_st_next    = rd_data[0];
                    cmp_valid_next = 1'b0;
                    state_next     = S_DECIDE;
                end
                else if (issue)
                begin
                    rd_en          = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[IDX_W-1:0];
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end
            S_DECIDE:
            begin
                res_valid = 1'b1;
                priority if (act_reg == ACTION_LOOKUP)
                begin
                    if (hit_reg)
                    begin
                        res.found         = 1'b1;
                        sel_slot          = CNT_W'(hit_idx_reg);
                        res.entry_enabled = hit_en_reg;
                        res.entry_stolen  = hit_st_reg;
                    end
                end
                else if (hit_reg)
                begin
                    res.found         = 1'b1;
                    sel_slot          = CNT_W'(hit_idx_reg);
                    res.entry_enabled = en_reg;
                    res.entry_stolen  = st_reg;
                    written           = 1'b1;
                end
                else if (full)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    sel_slot          = count_reg;
                    res.entry_enabled = en_reg;
                    res.entry_stolen  = st_reg;
                    written           = 1'b1;
                    wr_addr           = count_reg[IDX_W-1:0];
                end
                res.slot = SLOT_W'(sel_slot);
                if (written)
                begin
                    res.record_address = {res.slot, RECORD_BASE};
                end
                if (written && !hit_reg)
                begin
                    res.entry_count = COUNT_W'(count_reg + 1'b1);
                end
                else
                begin
                    res.entry_count = COUNT_W'(count_reg);
                end
                if (res_ready)
                begin
                    wr_en      = written;
                    state_next = S_IDLE;
                    if (written && !hit_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        key_reg     <= key_next;
        en_reg      <= en_next;
        st_reg      <= st_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_en_reg  <= hit_en_next;
        hit_st_reg  <= hit_st_next;
    end

endmodule
